// ----- design/lfs_pkg.sv -----
// ----------------------------------------------------------------------------
// lfs_pkg: shared types and constants for the line follower steering block
// Beat layouts for both channels, register indexes and fixed scale factors.
// ----------------------------------------------------------------------------
package lfs_pkg;

    localparam int READS_PER_EVENT = 3;
    localparam int RAW_NEED        = READS_PER_EVENT / 2 + 1;
    localparam logic [2:0] RAW_MASK =
        (READS_PER_EVENT >= 3) ? 3'b111 : 3'((1 << READS_PER_EVENT) - 1);

    localparam logic [7:0] SLOW_Q8    = 8'd154;
    localparam logic [7:0] BIAS_Q8    = 8'd205;
    localparam logic [7:0] TURN_EXTRA = 8'd10;
    localparam logic [7:0] DUTY_MAX   = 8'd255;

    localparam logic [15:0] TIMEOUT_RST = 16'd5000;
    localparam logic [7:0]  BASE_RST    = 8'd80;
    localparam logic [7:0]  TURN_RST    = 8'd75;
    localparam logic [7:0]  REVERSE_RST = 8'd65;

    typedef enum logic [2:0] {
        CFG_POLARITY = 3'd0,
        CFG_TIMEOUT  = 3'd1,
        CFG_BASE     = 3'd2,
        CFG_TURN     = 3'd3,
        CFG_REVERSE  = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [2:0]  left_reads;
        logic [2:0]  right_reads;
        logic [31:0] now_ms;
    } t_in_beat;

    typedef struct packed {
        logic       left_forward;
        logic [7:0] left_duty;
        logic       right_forward;
        logic [7:0] right_duty;
        logic       left_on_line;
        logic       right_on_line;
        logic       right_fault;
    } t_out_beat;

endpackage

// ----- design/line_follower_steering.sv -----
// ----------------------------------------------------------------------------
// line_follower_steering: two-sensor line follower steering
// Majority filters each sensor over raw reads and a history ring, tracks the
// right sensor timeout and drives direction and duty of both motors.
// ----------------------------------------------------------------------------
// an accepted input beat is registered into the result register unless a result is stalled
// throughput: one beat per cycle while the output is not stalled, set by the single result register
// a skid register takes one more beat while a result is stalled
// reset (synchronous, active low) restores register defaults, clears the
// history rings, slot and seen time, and marks the right sensor reliable
module line_follower_steering #(
    parameter int HISTORY_DEPTH = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lfs_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lfs_pkg::t_out_beat o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    localparam int SLOT_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HIST_NEED = HISTORY_DEPTH / 2 + 1;

    logic        r_polarity;
    logic [15:0] r_timeout;
    logic [7:0]  r_base;
    logic [7:0]  r_turn;
    logic [7:0]  r_reverse;

    logic [HISTORY_DEPTH-1:0] r_left_hist, n_left_hist;
    logic [HISTORY_DEPTH-1:0] r_right_hist, n_right_hist;
    logic [SLOT_W-1:0]        r_slot, n_slot;
    logic [31:0]              r_seen, n_seen;
    logic                     r_reliable, n_reliable;

    logic               r_out_valid, r_skid_valid;
    lfs_pkg::t_out_beat r_out, r_skid, n_res;

    logic        accept;
    logic        left_raw, right_raw, lon, ron;
    logic [31:0] elapsed;
    logic [15:0] slow_prod, bias_prod;
    logic [8:0]  turn_sum;
    logic [7:0]  turn_duty;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign accept      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polarity <= 1'b0;
            r_timeout  <= lfs_pkg::TIMEOUT_RST;
            r_base     <= lfs_pkg::BASE_RST;
            r_turn     <= lfs_pkg::TURN_RST;
            r_reverse  <= lfs_pkg::REVERSE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (lfs_pkg::t_cfg_index'(i_cfg_index))
                lfs_pkg::CFG_POLARITY: r_polarity <= i_cfg_data[0];
                lfs_pkg::CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                lfs_pkg::CFG_BASE:     r_base     <= i_cfg_data[7:0];
                lfs_pkg::CFG_TURN:     r_turn     <= i_cfg_data[7:0];
                lfs_pkg::CFG_REVERSE:  r_reverse  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        left_raw  = $countones(i_in_data.left_reads & lfs_pkg::RAW_MASK)
                    >= lfs_pkg::RAW_NEED;
        right_raw = $countones(i_in_data.right_reads & lfs_pkg::RAW_MASK)
                    >= lfs_pkg::RAW_NEED;

        n_left_hist          = r_left_hist;
        n_right_hist         = r_right_hist;
        n_left_hist[r_slot]  = left_raw;
        n_right_hist[r_slot] = right_raw;

        lon = (($countones(n_left_hist) >= HIST_NEED) == r_polarity);
        ron = (($countones(n_right_hist) >= HIST_NEED) == r_polarity);

        n_slot = (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : r_slot + 1'b1;

        elapsed    = i_in_data.now_ms - r_seen;
        n_seen     = r_seen;
        n_reliable = r_reliable;
        if (ron) begin
            n_seen     = i_in_data.now_ms;
            n_reliable = 1'b1;
        end else if (elapsed > {16'd0, r_timeout}) begin
            n_reliable = 1'b0;
        end

        slow_prod = r_base * lfs_pkg::SLOW_Q8;
        bias_prod = r_base * lfs_pkg::BIAS_Q8;
        turn_sum  = {1'b0, r_turn} + {1'b0, lfs_pkg::TURN_EXTRA};
        turn_duty = turn_sum[8] ? lfs_pkg::DUTY_MAX : turn_sum[7:0];

        n_res               = '0;
        n_res.left_on_line  = lon;
        n_res.right_on_line = ron;
        n_res.right_fault   = !n_reliable;
        priority if (!lon && !ron) begin
            n_res.left_forward  = 1'b1;
            n_res.left_duty     = r_base;
            n_res.right_forward = 1'b1;
            n_res.right_duty    = r_base;
        end else if (lon && ron) begin
            n_res.left_forward  = 1'b1;
            n_res.left_duty     = slow_prod[15:8];
            n_res.right_forward = 1'b1;
            n_res.right_duty    = slow_prod[15:8];
        end else if (lon && n_reliable) begin
            n_res.left_forward  = 1'b1;
            n_res.left_duty     = turn_duty;
            n_res.right_forward = 1'b0;
            n_res.right_duty    = r_reverse;
        end else if (lon) begin
            n_res.left_forward  = 1'b1;
            n_res.left_duty     = bias_prod[15:8];
            n_res.right_forward = 1'b1;
            n_res.right_duty    = r_base;
        end else begin
            n_res.left_forward  = 1'b0;
            n_res.left_duty     = r_reverse;
            n_res.right_forward = 1'b1;
            n_res.right_duty    = turn_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_hist  <= '0;
            r_right_hist <= '0;
            r_slot       <= '0;
            r_seen       <= '0;
            r_reliable   <= 1'b1;
        end else if (accept) begin
            r_left_hist  <= n_left_hist;
            r_right_hist <= n_right_hist;
            r_slot       <= n_slot;
            r_seen       <= n_seen;
            r_reliable   <= n_reliable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out <= r_skid_valid ? r_skid : n_res;
        end else if (accept) begin
            r_skid <= n_res;
        end
    end

    // skid beat only exists behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid beat without output beat");

    // a stalled result plus a new beat fills the skid
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && accept) |=> o_in_stall)
        else $error("beat lost while result stalled");

    // seeing the right line restores reliability
    a_right_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_res.right_on_line) |=> (r_reliable && r_seen == $past(i_in_data.now_ms)))
        else $error("right detection not recorded");

endmodule

// ----- tb/sv/line_follower_steering_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_follower_steering_tb: self-checking bench for the steering block
// Sensor events go in through a stalling driver fed from a queue, and a
// built-in predictor of the vote filters, fault timer and motor table forms
// the expected beat for each accepted event. Output beats are compared field
// by field. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module line_follower_steering_tb;

    localparam int HIST_DEPTH   = 3;
    localparam int HIST_NEED    = HIST_DEPTH / 2 + 1;
    localparam int PHASE_ITEMS  = 213;
    localparam int CALM_PHASE   = 4;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_LEN     = 80;
    localparam int LIMIT_CYCLES = 200000;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    lfs_pkg::t_in_beat  i_in_data   = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data  = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    lfs_pkg::t_out_beat o_out_data;
    logic               o_cfg_ready;

    // predictor copy of registers and state
    logic        cfg_polarity = 1'b0;
    logic [15:0] cfg_timeout  = lfs_pkg::TIMEOUT_RST;
    logic [7:0]  cfg_base     = lfs_pkg::BASE_RST;
    logic [7:0]  cfg_turn     = lfs_pkg::TURN_RST;
    logic [7:0]  cfg_reverse  = lfs_pkg::REVERSE_RST;
    logic        l_ring [HIST_DEPTH] = '{default: 1'b0};
    logic        r_ring [HIST_DEPTH] = '{default: 1'b0};
    int          ring_slot     = 0;
    logic [31:0] last_right_ms = '0;
    logic        right_ok      = 1'b1;

    lfs_pkg::t_in_beat  event_q [$];
    lfs_pkg::t_out_beat steer_expected_q [$];
    logic [31:0] gen_ms = '0;

    logic in_fire      = 1'b0;
    int   idle_pct     = 36;
    int   beats_in     = 0;
    int   checked      = 0;
    int   err_cnt      = 0;
    int   stall_cycles = 0;
    int   cycle_cnt    = 0;
    int   settings     = 1;
    int   hold_left    = 0;
    bit   hold_done    = 1'b0;

    line_follower_steering #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic lfs_pkg::t_out_beat steer_predict(lfs_pkg::t_in_beat b);
        lfs_pkg::t_out_beat o;
        int          l_cnt;
        int          r_cnt;
        logic        lon;
        logic        ron;
        logic [8:0]  fast;
        logic [7:0]  fast_duty;
        logic [15:0] slow_p;
        logic [15:0] bias_p;
        l_ring[ring_slot] = ($countones(b.left_reads & lfs_pkg::RAW_MASK)
                             >= lfs_pkg::RAW_NEED);
        r_ring[ring_slot] = ($countones(b.right_reads & lfs_pkg::RAW_MASK)
                             >= lfs_pkg::RAW_NEED);
        l_cnt = 0;
        r_cnt = 0;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            l_cnt += l_ring[i];
            r_cnt += r_ring[i];
        end
        lon = ((l_cnt >= HIST_NEED) == cfg_polarity);
        ron = ((r_cnt >= HIST_NEED) == cfg_polarity);
        if (ron) begin
            last_right_ms = b.now_ms;
            right_ok = 1'b1;
        end else if (b.now_ms - last_right_ms > 32'(cfg_timeout)) begin
            right_ok = 1'b0;
        end
        ring_slot = (ring_slot + 1 >= HIST_DEPTH) ? 0 : ring_slot + 1;

        fast      = 9'(cfg_turn) + 9'(lfs_pkg::TURN_EXTRA);
        fast_duty = (fast > 9'(lfs_pkg::DUTY_MAX)) ? lfs_pkg::DUTY_MAX : fast[7:0];
        slow_p    = 16'(cfg_base) * 16'(lfs_pkg::SLOW_Q8);
        bias_p    = 16'(cfg_base) * 16'(lfs_pkg::BIAS_Q8);
        o = '0;
        if (!lon && !ron) begin
            o.left_forward  = 1'b1;
            o.left_duty     = cfg_base;
            o.right_forward = 1'b1;
            o.right_duty    = cfg_base;
        end else if (lon && ron) begin
            o.left_forward  = 1'b1;
            o.left_duty     = slow_p[15:8];
            o.right_forward = 1'b1;
            o.right_duty    = slow_p[15:8];
        end else if (lon && right_ok) begin
            o.left_forward  = 1'b1;
            o.left_duty     = fast_duty;
            o.right_forward = 1'b0;
            o.right_duty    = cfg_reverse;
        end else if (lon) begin
            o.left_forward  = 1'b1;
            o.left_duty     = bias_p[15:8];
            o.right_forward = 1'b1;
            o.right_duty    = cfg_base;
        end else begin
            o.left_forward  = 1'b0;
            o.left_duty     = cfg_reverse;
            o.right_forward = 1'b1;
            o.right_duty    = fast_duty;
        end
        o.left_on_line  = lon;
        o.right_on_line = ron;
        o.right_fault   = ~right_ok;
        return o;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at result %0d: %s", checked, msg);
        err_cnt++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, want));
    endtask

    // monitor: both channels sampled at the rising edge
    always @(posedge i_clk) begin
        lfs_pkg::t_out_beat want;
        cycle_cnt++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (steer_expected_q.size() == 0) begin
                report_mismatch("result beat with nothing pending");
            end else begin
                want = steer_expected_q.pop_front();
                check_field("left_forward", o_out_data.left_forward, want.left_forward);
                check_field("left_duty", o_out_data.left_duty, want.left_duty);
                check_field("right_forward", o_out_data.right_forward, want.right_forward);
                check_field("right_duty", o_out_data.right_duty, want.right_duty);
                check_field("left_on_line", o_out_data.left_on_line, want.left_on_line);
                check_field("right_on_line", o_out_data.right_on_line, want.right_on_line);
                check_field("right_fault", o_out_data.right_fault, want.right_fault);
                checked++;
            end
        end
        in_fire = i_rst_n && i_in_valid && !o_in_stall;
        if (in_fire) begin
            steer_expected_q.push_back(steer_predict(i_in_data));
            beats_in++;
        end
        if (i_rst_n && i_in_valid && o_in_stall)
            stall_cycles++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_cnt, steer_expected_q.size());
            $display("** line_follower_steering: FAILED **");
            $finish;
        end
    end

    // event driver
    always @(negedge i_clk) begin
        if (!i_in_valid || in_fire) begin
            if (event_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_in_data  <= event_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back up the block
    always @(negedge i_clk) begin
        if (!hold_done && beats_in >= HOLD_AT) begin
            hold_left = HOLD_LEN;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            lfs_pkg::CFG_POLARITY: cfg_polarity = data[0];
            lfs_pkg::CFG_TIMEOUT:  cfg_timeout  = data;
            lfs_pkg::CFG_BASE:     cfg_base     = data[7:0];
            lfs_pkg::CFG_TURN:     cfg_turn     = data[7:0];
            lfs_pkg::CFG_REVERSE:  cfg_reverse  = data[7:0];
            default: ;
        endcase
    endtask

    // narrow registers get junk in the upper data bits
    task automatic set_config(logic pol, logic [15:0] tmo, logic [7:0] base,
                              logic [7:0] turn, logic [7:0] rev, bit bogus);
        write_reg(lfs_pkg::CFG_POLARITY, {15'($urandom), pol});
        write_reg(lfs_pkg::CFG_TIMEOUT, tmo);
        write_reg(lfs_pkg::CFG_BASE, {8'($urandom), base});
        write_reg(lfs_pkg::CFG_TURN, {8'($urandom), turn});
        write_reg(lfs_pkg::CFG_REVERSE, {8'($urandom), rev});
        if (bogus) begin
            for (int k = 1; k <= 3; k++)
                write_reg(3'(int'(lfs_pkg::CFG_REVERSE) + k), 16'($urandom));
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic settle();
        while (event_q.size() != 0 || i_in_valid || steer_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic add_event(logic [2:0] l, logic [2:0] r, logic [31:0] step);
        lfs_pkg::t_in_beat b;
        gen_ms        = gen_ms + step;
        b.left_reads  = l;
        b.right_reads = r;
        b.now_ms      = gen_ms;
        event_q.push_back(b);
    endtask

    // mode 0 steady low, mode 1 steady high, mode 2 noise; one bit may flip
    function automatic logic [2:0] sensor_reads(int mode);
        logic [2:0] v;
        v = (mode == 2) ? 3'($urandom) : (mode == 1 ? 3'b111 : 3'b000);
        if ($urandom_range(0, 4) == 0)
            v ^= 3'b001 << $urandom_range(0, 2);
        return v;
    endfunction

    // mostly small steps, often right at the fault timeout, now and then anything
    function automatic logic [31:0] ms_step();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 32'($urandom_range(0, 8));
        if (pick < 85)
            return 32'(cfg_timeout) + 32'($urandom_range(0, 2)) - 32'd1;
        return $urandom;
    endfunction

    task automatic queue_random(int count);
        int made;
        int run;
        int lmode;
        int rmode;
        made = 0;
        while (made < count) begin
            run = $urandom_range(1, 10);
            if ($urandom_range(0, 99) < 15) begin
                lmode = 2;
                rmode = 2;
            end else begin
                lmode = $urandom_range(0, 1);
                rmode = $urandom_range(0, 1);
            end
            repeat (run) begin
                add_event(sensor_reads(lmode), sensor_reads(rmode), ms_step());
                made++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: level low means on line
        add_event(3'b000, 3'b000, 32'd0);
        add_event(3'b000, 3'b000, 32'd1);
        add_event(3'b000, 3'b000, 32'd1);
        repeat (3) add_event(3'b111, 3'b111, 32'd1);
        repeat (3) add_event(3'b000, 3'b111, 32'd1);
        repeat (3) add_event(3'b111, 3'b000, 32'd1);
        // right lost past the timeout while left holds the line
        add_event(3'b000, 3'b111, 32'd1);
        add_event(3'b000, 3'b111, 32'd1);
        add_event(3'b000, 3'b111, 32'd5001);
        add_event(3'b000, 3'b111, 32'd1);
        // split votes and a wrap of the ms counter
        add_event(3'b011, 3'b100, 32'hFFFF_FFFF - gen_ms);
        add_event(3'b101, 3'b110, 32'd1);
        add_event(3'b010, 3'b001, 32'd1);
        add_event(3'b000, 3'b000, 32'd1);
        add_event(3'b000, 3'b000, 32'd1);

        for (int ph = 1; ph <= 6; ph++) begin
            settle();
            idle_pct = (ph == CALM_PHASE) ? 0 : 36;
            case (ph)
                1: set_config(1'b1, 16'd0, 8'd255, 8'd255, 8'd255, 1'b0);
                2: set_config(1'b0, 16'hFFFF, 8'd0, 8'd0, 8'd0, 1'b1);
                3: set_config(1'b1, 16'd40, 8'd128, 8'd245, 8'd1, 1'b0);
                4: set_config(1'b0, 16'd12, 8'd200, 8'd246, 8'd90, 1'b0);
                default: set_config(1'($urandom),
                                    $urandom_range(0, 1) ? 16'($urandom_range(0, 80))
                                                         : 16'($urandom),
                                    8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
            endcase
            @(posedge i_clk);
            if (ph == 3)
                gen_ms = $urandom;
            queue_random(PHASE_ITEMS);
        end
        settle();
        repeat (4) @(posedge i_clk);

        $display("covered %0d sensor events under %0d register settings, %0d results checked",
                 beats_in, settings, checked);
        $display("input held back for %0d cycles, %0d mismatches", stall_cycles, err_cnt);
        if (err_cnt == 0) begin
            $display("** line_follower_steering: PASSED **");
        end else begin
            $display("** line_follower_steering: FAILED **");
        end
        $finish;
    end

endmodule
